// ----- src/b2d_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII converter.
`default_nettype none

package b2d_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 10;
    localparam int DIGIT_LIMIT     = 20;
    localparam int IN_WIDTH        = 32;
    localparam int CHAR_WIDTH      = 6;

    // Upper two bits of the 6-bit ASCII digit code ('0' = 6'b11_0000)
    localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic digit_shift;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic skip;
        logic last;
    } t_status;

endpackage

`default_nettype wire

// ----- src/b2d_ctrl.sv -----
// Controller state machine for the binary to decimal ASCII converter.
`default_nettype none

module b2d_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire b2d_pkg::t_status i_status,
    output b2d_pkg::t_cmd         o_cmd
);
    import b2d_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CONV;
            end
            S_CONV: begin
                if (i_status.conv_done) n_state = S_SKIP;
            end
            S_SKIP: begin
                if (!i_status.skip) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_out_stall && i_status.last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.load  = i_in_valid;
            end
            S_CONV: begin
                o_cmd.conv_step = !i_status.conv_done;
            end
            S_SKIP: begin
                o_cmd.digit_shift = i_status.skip;
            end
            S_EMIT: begin
                o_out_valid       = 1'b1;
                o_cmd.digit_shift = !i_out_stall && !i_status.last;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/b2d_datapath.sv -----
// Shift-and-add-3 datapath and digit shift-out register for the converter.
`default_nettype none

module b2d_datapath #(
    parameter int VALUE_WIDTH = b2d_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = b2d_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire b2d_pkg::t_cmd                      i_cmd,
    input  wire logic [b2d_pkg::IN_WIDTH-1:0]       i_value,
    output b2d_pkg::t_status                        o_status,
    output logic [b2d_pkg::CHAR_WIDTH-1:0]          o_digit_char
);
    import b2d_pkg::*;

    localparam int CONV_W = (VALUE_WIDTH < IN_WIDTH) ? VALUE_WIDTH : IN_WIDTH;
    localparam int NDIG   = ((CONV_W * 1233) >> 12) + 1;
    localparam int CAP_LO = (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;
    localparam int CAP    = (CAP_LO > DIGIT_LIMIT) ? DIGIT_LIMIT : CAP_LO;
    localparam int BCD_W  = NDIG * 4;
    localparam int POS_W  = $clog2(NDIG);
    localparam int CNT_W  = $clog2(CONV_W + 1);

    logic [CONV_W-1:0] r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [CNT_W-1:0]  r_bitcnt;
    logic [POS_W-1:0]  r_pos;
    logic              r_seen_digit;
    logic [BCD_W-1:0]  adj;
    logic [3:0]        top_digit;

    // Add three to every digit of five or more ahead of the shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin        <= i_value[CONV_W-1:0];
            r_bcd        <= '0;
            r_bitcnt     <= CNT_W'(CONV_W);
            r_pos        <= POS_W'(NDIG - 1);
            r_seen_digit <= 1'b0;
        end else if (i_cmd.conv_step) begin
            r_bcd    <= {adj[BCD_W-2:0], r_bin[CONV_W-1]};
            r_bin    <= {r_bin[CONV_W-2:0], 1'b0};
            r_bitcnt <= r_bitcnt - 1'b1;
        end else if (i_cmd.digit_shift) begin
            r_bcd        <= {r_bcd[BCD_W-5:0], 4'd0};
            r_pos        <= r_pos - 1'b1;
            // a nonzero digit above makes every zero below it significant
            r_seen_digit <= r_seen_digit | (top_digit != 4'd0);
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: 4];

    always_comb begin
        o_status.conv_done = (r_bitcnt == '0);
        // Drop digits above the buffer size and leading zeros
        o_status.skip      = (32'(r_pos) >= CAP) ||
                             ((top_digit == 4'd0) && (r_pos != '0) && !r_seen_digit);
        o_status.last      = (r_pos == '0);
    end

    assign o_digit_char = {ASCII_DIGIT_HI, top_digit};

endmodule

`default_nettype wire

// ----- src/binary_to_decimal_ascii.sv -----
// Sequence: one accept in idle, min(VALUE_WIDTH, IN_WIDTH) shift-and-add-3 steps,
// then each digit position in turn is skipped or emitted.
// Throughput: one value at a time, set by the serial double-dabble loop; the next
// value is taken once the last digit transaction completes.
// Reset: synchronous, active low; clears the controller to idle, no results pending.
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = b2d_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = b2d_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel: one transaction per number
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [b2d_pkg::IN_WIDTH-1:0]  i_value,
    // output channel: one transaction per ASCII digit, most significant first
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [b2d_pkg::CHAR_WIDTH-1:0]     o_digit_char,
    output logic                               o_last_digit
);
    import b2d_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Controller: idle -> convert (one bit per cycle) -> skip leading zeros and digits
    // above the cap -> emit digits, holding each digit while the output stalls.
    b2d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: binary shift register, BCD accumulator and digit counters.
    // The top BCD digit is the character on the output; it only moves on a
    // shift command, so a stalled digit stays put.
    b2d_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .o_status     (status),
        .o_digit_char (o_digit_char)
    );

    // The digit at position zero closes the number.
    assign o_last_digit = status.last;

    // No new number is taken while digits are pending.
    a_busy_when_emitting: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> o_stall
    ) else $error("input taken while a digit is pending");

    // Every emitted character is a decimal digit.
    a_digit_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char >= 6'd48 && o_digit_char <= 6'd57)
    ) else $error("emitted character is not a decimal digit");

    // A freshly accepted number cannot show a digit before conversion.
    a_no_early_digit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !o_valid
    ) else $error("digit shown right after accept");

    // After the final digit transaction the block is ready again.
    a_ready_after_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_digit) |=> (!o_stall && !o_valid)
    ) else $error("block not idle after last digit");

endmodule

`default_nettype wire
